[design/lfr_pkg.sv]
// ----------------------------------------------------------------------------
// Line and frame receiver package
// Shared types and constants: phase and status codes, opcodes, buffer sizing.
// ----------------------------------------------------------------------------
package lfr_pkg;

    // Buffer geometry. The write index can hold the depth itself, so that a
    // full buffer is detected before the next write.
    localparam int BUFFER_DEPTH = 64;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
    localparam int WIDX_W       = $clog2(BUFFER_DEPTH + 1);

    // Special characters.
    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] CHAR_O     = 8'h4F;
    localparam logic [7:0] CHAR_K     = 8'h4B;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LINE       = 3'd1,
        PH_LINE_HELD  = 3'd2,
        PH_LEN_HIGH   = 3'd3,
        PH_LEN_LOW    = 3'd4,
        PH_DATA       = 3'd5,
        PH_FRAME_HELD = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_ACCEPT     = 3'd0,
        ST_LINE_DONE  = 3'd1,
        ST_FRAME_DONE = 3'd2,
        ST_OVERFLOW   = 3'd3,
        ST_OVERRUN    = 3'd4
    } t_status;

endpackage

[design/line_and_frame_receiver.sv]
// ----------------------------------------------------------------------------
// Line and frame receiver
// Gathers command lines or length-prefixed frames from a serial byte stream
// into a byte buffer and answers buffer reads.
// ----------------------------------------------------------------------------
// Usage:
// Each input word carries an opcode (received byte, release held result, read
// buffer entry, no operation), a data byte and a read index. Every accepted
// word produces exactly one result word: a status code, the receiver phase
// after the word, the current frame length, a flag telling whether the buffer
// starts with "OK", and the buffer byte for read words (zero otherwise).
// The input channel accepts a word when i_in_valid is high and o_in_stall is
// low; the output channel hands over a word when o_out_valid is high and
// i_out_stall is low. A result appears in the cycle after its input word, and one
// word per cycle is sustained without a stall: the phase update, the single buffer
// write and the registered buffer read all happen together. The result register
// lets a new word enter in the same cycle that the previous result is taken; while
// a result waits under a stall, o_in_stall is raised and nothing moves.
// The api_mode register is written on the configuration channel
// (i_cfg_valid with o_cfg_ready, always ready) and should only change while
// the block is idle. Reset returns the receiver to idle with an empty result
// register; the buffer contents are left as they were and read as unknown
// until written.
// ----------------------------------------------------------------------------
module line_and_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic [5:0]  i_read_index,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_phase,
    output logic [15:0] o_frame_length,
    output logic        o_line_is_ok,
    output logic [7:0]  o_read_data
);
    import lfr_pkg::*;

    // Configuration register.
    logic r_api_mode;

    // Receiver state.
    t_phase              r_phase, n_phase;
    logic [WIDX_W-1:0]   r_widx, n_widx;
    logic [15:0]         r_len, n_len;

    // Copies of buffer entries 0 and 1, kept for the "OK" check so that the
    // buffer memory needs only one read port.
    logic [7:0]          r_buf0, n_buf0;
    logic [7:0]          r_buf1, n_buf1;

    // Buffer memory with a registered read port.
    logic [7:0]          r_mem [BUFFER_DEPTH];
    logic [7:0]          r_mem_q;

    // Result register. Phase, length and the "OK" flag come straight from the
    // state registers, which only change when a new word is accepted, i.e.
    // together with the result register.
    logic                r_out_valid;
    t_status             r_status, n_status;
    logic                r_rd_sel, n_rd_sel;

    logic                w_accept;
    logic                w_start;
    t_phase              w_ph;
    logic                w_wr_en;
    logic [BUF_AW-1:0]   w_wr_addr;
    logic [7:0]          w_wr_data;
    logic [BUF_AW-1:0]   w_rd_addr;
    logic                w_rd_in_range;

    assign o_cfg_ready = 1'b1;

    // The input stalls only while a finished result still waits downstream.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_rd_addr     = BUF_AW'(i_read_index);
    assign w_rd_in_range = (32'(i_read_index) < BUFFER_DEPTH);

    // A start byte in frame mode aborts anything in progress, held results
    // included, before the byte is looked at.
    assign w_start = r_api_mode & (i_data_byte == START_BYTE);

    always_comb begin
        n_phase   = r_phase;
        n_widx    = r_widx;
        n_len     = r_len;
        n_status  = ST_ACCEPT;
        n_rd_sel  = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = BUF_AW'(r_widx);
        w_wr_data = i_data_byte;
        w_ph      = w_start ? PH_IDLE : r_phase;

        case (t_opcode'(i_opcode))
            OP_BYTE: begin
                case (w_ph)
                    PH_LINE: begin
                        if (r_widx >= WIDX_W'(BUFFER_DEPTH)) begin
                            n_status = ST_OVERFLOW;
                            n_phase  = PH_IDLE;
                        end else begin
                            w_wr_en = 1'b1;
                            if (i_data_byte == CR_BYTE) begin
                                // The carriage return is stored as a terminating zero.
                                w_wr_data = CHAR_NUL;
                                n_phase   = PH_LINE_HELD;
                                n_status  = ST_LINE_DONE;
                            end
                            n_widx = r_widx + WIDX_W'(1);
                        end
                    end
                    PH_LINE_HELD, PH_FRAME_HELD: begin
                        // The held result stays; the byte is dropped.
                        n_status = ST_OVERRUN;
                    end
                    PH_LEN_HIGH: begin
                        n_len   = {i_data_byte, 8'h00};
                        n_phase = PH_LEN_LOW;
                    end
                    PH_LEN_LOW: begin
                        n_len   = r_len | {8'h00, i_data_byte};
                        n_widx  = '0;
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        if (r_widx >= WIDX_W'(BUFFER_DEPTH)) begin
                            n_status = ST_OVERFLOW;
                            n_phase  = PH_IDLE;
                        end else begin
                            w_wr_en = 1'b1;
                            // The frame holds length plus one bytes, the last one
                            // being the checksum.
                            if (16'(r_widx) == r_len) begin
                                n_phase  = PH_FRAME_HELD;
                                n_status = ST_FRAME_DONE;
                            end else begin
                                n_widx = r_widx + WIDX_W'(1);
                            end
                        end
                    end
                    default: begin
                        // Idle: a lone carriage return is ignored.
                        if (i_data_byte != CR_BYTE) begin
                            if (w_start) begin
                                n_widx  = '0;
                                n_phase = PH_LEN_HIGH;
                            end else begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = '0;
                                n_widx    = WIDX_W'(1);
                                n_phase   = PH_LINE;
                            end
                        end
                    end
                endcase
            end
            OP_RELEASE: begin
                if (r_phase == PH_LINE_HELD || r_phase == PH_FRAME_HELD) begin
                    n_phase = PH_IDLE;
                end
            end
            OP_READ: begin
                n_rd_sel = w_rd_in_range;
            end
            default: begin
            end
        endcase

        n_buf0 = r_buf0;
        n_buf1 = r_buf1;
        if (w_wr_en && w_wr_addr == BUF_AW'(0)) begin
            n_buf0 = w_wr_data;
        end
        if (w_wr_en && w_wr_addr == BUF_AW'(1)) begin
            n_buf1 = w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_api_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_api_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_widx      <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_widx      <= n_widx;
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_rd_sel <= n_rd_sel;
            r_buf0   <= n_buf0;
            r_buf1   <= n_buf1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem_q <= r_mem[w_rd_addr];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_phase        = r_phase;
    assign o_frame_length = r_len;
    assign o_line_is_ok   = (r_buf0 == CHAR_O) && (r_buf1 == CHAR_K);
    assign o_read_data    = r_rd_sel ? r_mem_q : 8'h00;

    // The write index never runs past the buffer depth.
    a_widx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_widx <= WIDX_W'(BUFFER_DEPTH))
        else $error("write index beyond buffer depth");

    // Waiting for the low length byte, the low half of the length is clear.
    a_len_low_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LEN_LOW |-> r_len[7:0] == 8'h00)
        else $error("length low byte not clear before it is received");

    // A completion status always comes with the matching held phase.
    a_done_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_FRAME_DONE |-> r_phase == PH_FRAME_HELD)
        else $error("frame complete without frame held phase");

    a_line_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_LINE_DONE |-> r_phase == PH_LINE_HELD)
        else $error("line complete without line held phase");

    // A byte that is not a start byte, arriving while a result is held,
    // is reported as an overrun and leaves the phase alone.
    a_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_opcode == OP_BYTE && !w_start &&
        (r_phase == PH_LINE_HELD || r_phase == PH_FRAME_HELD)
        |=> r_status == ST_OVERRUN && $stable(r_phase))
        else $error("byte while held not reported as overrun");

endmodule
